// ===== src/affine_vertex_place_with_bounds_assert.svh =====
// Assertion macros for the vertex placement block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef AFFINE_VERTEX_PLACE_WITH_BOUNDS_ASSERT_SVH
`define AFFINE_VERTEX_PLACE_WITH_BOUNDS_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define AVF_CHECK_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define AVF_CHECK_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== src/avf_pkg.sv =====
// Shared types and constants for the vertex placement block.
// No dependencies.
package avf_pkg;

    localparam int COORD_W = 24;
    localparam int COEF_W  = 16;
    localparam int TEX_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic        [TEX_W-1:0]   t_tex;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_COEF_A  = 3'd0;
    localparam t_cfg_idx CFG_COEF_B  = 3'd1;
    localparam t_cfg_idx CFG_COEF_C  = 3'd2;
    localparam t_cfg_idx CFG_COEF_D  = 3'd3;
    localparam t_cfg_idx CFG_SHIFT_X = 3'd4;
    localparam t_cfg_idx CFG_SHIFT_Y = 3'd5;

    localparam t_coef  COEF_ONE  = 16'sd4096;
    localparam t_coef  COEF_ZERO = 16'sd0;
    localparam t_coord COORD_MAX = 24'sh7FFFFF;
    localparam t_coord COORD_MIN = 24'sh800000;
    localparam t_coord COORD_ZERO = 24'sd0;

    typedef struct packed {
        t_coef  coef_a;
        t_coef  coef_b;
        t_coef  coef_c;
        t_coef  coef_d;
        t_coord shift_x;
        t_coord shift_y;
    } t_xform_cfg;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord max_x;
        t_coord max_y;
    } t_box;

endpackage

// ===== src/avf_cfg.sv =====
// Configuration register file: affine coefficients and translation.
// Depends on avf_pkg.
module avf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  avf_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [avf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output avf_pkg::t_xform_cfg           o_cfg
);
    import avf_pkg::*;

    t_xform_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_a  <= COEF_ONE;
            r_cfg.coef_b  <= COEF_ZERO;
            r_cfg.coef_c  <= COEF_ZERO;
            r_cfg.coef_d  <= COEF_ONE;
            r_cfg.shift_x <= COORD_ZERO;
            r_cfg.shift_y <= COORD_ZERO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_A:  r_cfg.coef_a  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_B:  r_cfg.coef_b  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_C:  r_cfg.coef_c  <= i_cfg_data[COEF_W-1:0];
                CFG_COEF_D:  r_cfg.coef_d  <= i_cfg_data[COEF_W-1:0];
                CFG_SHIFT_X: r_cfg.shift_x <= i_cfg_data[COORD_W-1:0];
                CFG_SHIFT_Y: r_cfg.shift_y <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/avf_xform.sv =====
// Affine placement datapath: offset add, 2x2 multiply, floor shift,
// translation and saturation. Depends on avf_pkg.
module avf_xform #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  avf_pkg::t_xform_cfg i_cfg,
    input  avf_pkg::t_coord     i_pos_x,
    input  avf_pkg::t_coord     i_pos_y,
    input  avf_pkg::t_coord     i_off_x,
    input  avf_pkg::t_coord     i_off_y,
    output avf_pkg::t_coord     o_placed_x,
    output avf_pkg::t_coord     o_placed_y
);
    import avf_pkg::*;

    localparam int SUM_W  = COORD_W + 1;
    localparam int PROD_W = SUM_W + COEF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RES_W  = ACC_W + 1;

    logic signed [SUM_W-1:0]  x;
    logic signed [SUM_W-1:0]  y;
    logic signed [PROD_W-1:0] p_ax, p_by, p_cx, p_dy;
    logic signed [ACC_W-1:0]  acc_x, acc_y;
    logic signed [RES_W-1:0]  res_x, res_y;

    function automatic t_coord sat(input logic signed [RES_W-1:0] v);
        if (v > RES_W'(signed'(COORD_MAX))) begin
            sat = COORD_MAX;
        end else if (v < RES_W'(signed'(COORD_MIN))) begin
            sat = COORD_MIN;
        end else begin
            sat = v[COORD_W-1:0];
        end
    endfunction

    always_comb begin
        x = SUM_W'(i_pos_x) + SUM_W'(i_off_x);
        y = SUM_W'(i_pos_y) + SUM_W'(i_off_y);
        p_ax = PROD_W'(x) * PROD_W'(i_cfg.coef_a);
        p_by = PROD_W'(y) * PROD_W'(i_cfg.coef_b);
        p_cx = PROD_W'(x) * PROD_W'(i_cfg.coef_c);
        p_dy = PROD_W'(y) * PROD_W'(i_cfg.coef_d);
        acc_x = ACC_W'(p_ax) + ACC_W'(p_by);
        acc_y = ACC_W'(p_cx) + ACC_W'(p_dy);
        res_x = RES_W'(acc_x >>> COEF_FRAC_BITS) + RES_W'(i_cfg.shift_x);
        res_y = RES_W'(acc_y >>> COEF_FRAC_BITS) + RES_W'(i_cfg.shift_y);
        o_placed_x = sat(res_x);
        o_placed_y = sat(res_y);
    end

endmodule

// ===== src/avf_bounds.sv =====
// Running bounding box of placed points, cleared by the start flag.
// Depends on avf_pkg.
module avf_bounds (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_update,
    input  logic            i_start,
    input  avf_pkg::t_coord i_px,
    input  avf_pkg::t_coord i_py,
    output avf_pkg::t_box   o_box
);
    import avf_pkg::*;

    t_box r_box;
    t_box base;
    t_box n_box;

    always_comb begin
        if (i_start) begin
            base.min_x = COORD_MAX;
            base.min_y = COORD_MAX;
            base.max_x = COORD_MIN;
            base.max_y = COORD_MIN;
        end else begin
            base = r_box;
        end
        n_box.min_x = (i_px < base.min_x) ? i_px : base.min_x;
        n_box.min_y = (i_py < base.min_y) ? i_py : base.min_y;
        n_box.max_x = (i_px > base.max_x) ? i_px : base.max_x;
        n_box.max_y = (i_py > base.max_y) ? i_py : base.max_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.min_x <= COORD_MAX;
            r_box.min_y <= COORD_MAX;
            r_box.max_x <= COORD_MIN;
            r_box.max_y <= COORD_MIN;
        end else if (i_update) begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

// ===== src/affine_vertex_place_with_bounds.sv =====
// Top level: vertex placement with a running bounding box.
// Depends on avf_pkg, avf_cfg, avf_xform, avf_bounds and the assertion header.
//
//   channel  valid        ready        payload
//   in       i_in_valid   o_in_ready   i_start_list, i_pos_*, i_off_*, i_tex_*
//   out      o_out_valid  i_out_ready  o_placed_*, o_out_u/v, o_box_*
//   cfg      i_cfg_we     (none)       i_cfg_idx, i_cfg_data
//
// An accepted request passes the input register, then the result register.
// One request per cycle when not stalled; box min/max feedback is one compare stage.
// Reset clears both valid flags and the box, and loads the identity transform.
// A stalled output holds the result; the input register still takes a new
// request whenever the result register is free or being drained.
module affine_vertex_place_with_bounds #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  avf_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [avf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_start_list,
    input  avf_pkg::t_coord                i_pos_x,
    input  avf_pkg::t_coord                i_pos_y,
    input  avf_pkg::t_coord                i_off_x,
    input  avf_pkg::t_coord                i_off_y,
    input  avf_pkg::t_tex                  i_tex_u,
    input  avf_pkg::t_tex                  i_tex_v,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output avf_pkg::t_coord                o_placed_x,
    output avf_pkg::t_coord                o_placed_y,
    output avf_pkg::t_tex                  o_out_u,
    output avf_pkg::t_tex                  o_out_v,
    output avf_pkg::t_coord                o_box_min_x,
    output avf_pkg::t_coord                o_box_min_y,
    output avf_pkg::t_coord                o_box_max_x,
    output avf_pkg::t_coord                o_box_max_y
);
    import avf_pkg::*;

    t_xform_cfg cfg;
    t_box       box;

    logic   r_s1_vld;
    logic   r_s1_start;
    t_coord r_s1_pos_x, r_s1_pos_y, r_s1_off_x, r_s1_off_y;
    t_tex   r_s1_u, r_s1_v;

    logic   r_out_vld;
    t_coord r_out_x, r_out_y;
    t_tex   r_out_u, r_out_v;

    t_coord px, py;
    logic   in_acc;
    logic   advance;

    assign advance    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || advance;
    assign in_acc     = i_in_valid && o_in_ready;

    avf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    avf_xform #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_xform (
        .i_cfg      (cfg),
        .i_pos_x    (r_s1_pos_x),
        .i_pos_y    (r_s1_pos_y),
        .i_off_x    (r_s1_off_x),
        .i_off_y    (r_s1_off_y),
        .o_placed_x (px),
        .o_placed_y (py)
    );

    avf_bounds u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_start  (r_s1_start),
        .i_px     (px),
        .i_py     (py),
        .o_box    (box)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_start <= i_start_list;
            r_s1_pos_x <= i_pos_x;
            r_s1_pos_y <= i_pos_y;
            r_s1_off_x <= i_off_x;
            r_s1_off_y <= i_off_y;
            r_s1_u     <= i_tex_u;
            r_s1_v     <= i_tex_v;
        end
        if (advance) begin
            r_out_x <= px;
            r_out_y <= py;
            r_out_u <= r_s1_u;
            r_out_v <= r_s1_v;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_placed_x  = r_out_x;
    assign o_placed_y  = r_out_y;
    assign o_out_u     = r_out_u;
    assign o_out_v     = r_out_v;
    assign o_box_min_x = box.min_x;
    assign o_box_min_y = box.min_y;
    assign o_box_max_x = box.max_x;
    assign o_box_max_y = box.max_y;

`include "affine_vertex_place_with_bounds_assert.svh"

    `AVF_CHECK_NOW(a_box_x_order, o_out_valid, o_box_min_x <= o_box_max_x, "box x inverted")
    `AVF_CHECK_NOW(a_box_y_order, o_out_valid, o_box_min_y <= o_box_max_y, "box y inverted")
    `AVF_CHECK_NOW(a_x_in_box, o_out_valid, (o_box_min_x <= o_placed_x) && (o_placed_x <= o_box_max_x), "x outside box")
    `AVF_CHECK_NOW(a_y_in_box, o_out_valid, (o_box_min_y <= o_placed_y) && (o_placed_y <= o_box_max_y), "y outside box")
    `AVF_CHECK_NEXT(a_accept_fills, in_acc, r_s1_vld, "accepted request lost")

endmodule

// ===== bench/testbench.sv =====
// Testbench for affine_vertex_place_with_bounds: random and directed vertex streams
// with random stalls on both channels, checked against an in-bench placement predictor.
// Depends on avf_pkg and the affine_vertex_place_with_bounds top level.
module testbench;
    import avf_pkg::*;

    localparam int COEF_FRAC_BITS = 12;
    localparam int HOLD_PHASE = 3;
    localparam int HOLD_CYCLES = 300;
    localparam t_cfg_idx CFG_SPARE_6 = 3'd6;
    localparam t_cfg_idx CFG_SPARE_7 = 3'd7;
    localparam t_coef COEF_LOW  = 16'sh8000;
    localparam t_coef COEF_HIGH = 16'sh7FFF;

    typedef struct packed {
        logic   start_list;
        t_coord pos_x;
        t_coord pos_y;
        t_coord off_x;
        t_coord off_y;
        t_tex   tex_u;
        t_tex   tex_v;
    } t_vertex;

    typedef struct packed {
        t_coord placed_x;
        t_coord placed_y;
        t_tex   out_u;
        t_tex   out_v;
        t_coord min_x;
        t_coord min_y;
        t_coord max_x;
        t_coord max_y;
    } t_placed;

    class vertex_placer;
        t_coef   coef_a, coef_b, coef_c, coef_d;
        t_coord  shift_x, shift_y;
        t_coord  low_x, low_y, high_x, high_y;
        t_placed placements_due[$];
        int      bad_results;
        int      results_seen;

        function new();
            coef_a = COEF_ONE;
            coef_b = COEF_ZERO;
            coef_c = COEF_ZERO;
            coef_d = COEF_ONE;
            shift_x = COORD_ZERO;
            shift_y = COORD_ZERO;
            bad_results = 0;
            results_seen = 0;
            clear_box();
        endfunction

        function void clear_box();
            low_x = COORD_MAX;
            low_y = COORD_MAX;
            high_x = COORD_MIN;
            high_y = COORD_MIN;
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COEF_A: coef_a = t_coef'(data[COEF_W-1:0]);
                CFG_COEF_B: coef_b = t_coef'(data[COEF_W-1:0]);
                CFG_COEF_C: coef_c = t_coef'(data[COEF_W-1:0]);
                CFG_COEF_D: coef_d = t_coef'(data[COEF_W-1:0]);
                CFG_SHIFT_X: shift_x = t_coord'(data);
                CFG_SHIFT_Y: shift_y = t_coord'(data);
                default: ;
            endcase
        endfunction

        function t_coord clamp_coord(longint v);
            if (v > longint'(COORD_MAX)) return COORD_MAX;
            if (v < longint'(COORD_MIN)) return COORD_MIN;
            return t_coord'(v);
        endfunction

        function void note_vertex(t_vertex v);
            longint  x, y, sx, sy;
            t_placed r;
            x = longint'(v.pos_x) + longint'(v.off_x);
            y = longint'(v.pos_y) + longint'(v.off_y);
            sx = longint'(coef_a) * x + longint'(coef_b) * y;
            sy = longint'(coef_c) * x + longint'(coef_d) * y;
            r.placed_x = clamp_coord((sx >>> COEF_FRAC_BITS) + longint'(shift_x));
            r.placed_y = clamp_coord((sy >>> COEF_FRAC_BITS) + longint'(shift_y));
            if (v.start_list) clear_box();
            if (r.placed_x < low_x) low_x = r.placed_x;
            if (r.placed_y < low_y) low_y = r.placed_y;
            if (r.placed_x > high_x) high_x = r.placed_x;
            if (r.placed_y > high_y) high_y = r.placed_y;
            r.out_u = v.tex_u;
            r.out_v = v.tex_v;
            r.min_x = low_x;
            r.min_y = low_y;
            r.max_x = high_x;
            r.max_y = high_y;
            placements_due = {placements_due, r};
        endfunction

        function string show(t_placed r);
            return $sformatf("x=%0d y=%0d u=%h v=%h box=(%0d,%0d)..(%0d,%0d)",
                r.placed_x, r.placed_y, r.out_u, r.out_v,
                r.min_x, r.min_y, r.max_x, r.max_y);
        endfunction

        function void check_placement(t_placed got);
            t_placed want;
            bit      missing;
            missing = (placements_due.size() == 0);
            want = missing ? '0 : placements_due.pop_front();
            results_seen++;
            if (missing || got !== want) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("result %0d %s", results_seen,
                        missing ? "arrived with none pending" : "differs");
                    $display("  expected %s", missing ? "nothing" : show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function int outstanding();
            return placements_due.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_vertex               offer;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_coord                o_placed_x, o_placed_y;
    t_tex                  o_out_u, o_out_v;
    t_coord                o_box_min_x, o_box_min_y, o_box_max_x, o_box_max_y;
    t_placed               seen;

    vertex_placer placer;
    int           phase_no = -1;
    bit           calm = 1'b0;
    bit           held = 1'b0;

    assign seen = {o_placed_x, o_placed_y, o_out_u, o_out_v,
                   o_box_min_x, o_box_min_y, o_box_max_x, o_box_max_y};

    affine_vertex_place_with_bounds #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_list (offer.start_list),
        .i_pos_x      (offer.pos_x),
        .i_pos_y      (offer.pos_y),
        .i_off_x      (offer.off_x),
        .i_off_y      (offer.off_y),
        .i_tex_u      (offer.tex_u),
        .i_tex_v      (offer.tex_v),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_placed_x   (o_placed_x),
        .o_placed_y   (o_placed_y),
        .o_out_u      (o_out_u),
        .o_out_v      (o_out_v),
        .o_box_min_x  (o_box_min_x),
        .o_box_min_y  (o_box_min_y),
        .o_box_max_x  (o_box_max_x),
        .o_box_max_y  (o_box_max_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("affine_vertex_place_with_bounds: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) placer.note_vertex(offer);
            if (o_out_valid && i_out_ready) placer.check_placement(seen);
        end
    end

    // receiver: random stall bursts, one long hold-off, steady ready at the end
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if (phase_no == HOLD_PHASE && !held) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic push_vertex(t_vertex v);
        i_in_valid <= 1'b1;
        offer <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_input(int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (placer.outstanding() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        placer.apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic program_transform(t_coef a, t_coef b, t_coef c, t_coef d,
                                     t_coord sx, t_coord sy);
        logic [7:0] junk;
        junk = 8'($urandom);
        write_reg(CFG_COEF_A, {junk, a});
        junk = 8'($urandom);
        write_reg(CFG_COEF_B, {junk, b});
        junk = 8'($urandom);
        write_reg(CFG_COEF_C, {junk, c});
        junk = 8'($urandom);
        write_reg(CFG_COEF_D, {junk, d});
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        if ($urandom_range(0, 1) != 0)
            write_reg($urandom_range(0, 1) != 0 ? CFG_SPARE_6 : CFG_SPARE_7,
                      CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_vertex make_vertex(bit start, t_coord px, t_coord py,
                                            t_coord ox, t_coord oy, t_tex u, t_tex v);
        t_vertex r;
        r.start_list = start;
        r.pos_x = px;
        r.pos_y = py;
        r.off_x = ox;
        r.off_y = oy;
        r.tex_u = u;
        r.tex_v = v;
        return r;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3: return t_coord'($urandom);
            default: return t_coord'(int'($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    function automatic t_coord rand_offset();
        return ($urandom_range(0, 2) == 0) ? COORD_ZERO : rand_coord();
    endfunction

    function automatic t_coef rand_coef();
        case ($urandom_range(0, 5))
            0: return COEF_LOW;
            1: return COEF_HIGH;
            2: return COEF_ZERO;
            3: return t_coef'($urandom);
            default: return t_coef'(int'(COEF_ONE) + int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    task automatic run_lists(int count);
        int  sent;
        int  len;
        bit  bursty;
        bit  start;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 24);
            bursty = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < len && sent < count; k++) begin
                start = (k == 0);
                if ($urandom_range(0, 15) == 0) start = $urandom_range(0, 1);
                if (!calm && bursty && $urandom_range(0, 3) == 0)
                    idle_input($urandom_range(1, 16));
                push_vertex(make_vertex(start, rand_coord(), rand_coord(),
                    rand_offset(), rand_offset(), t_tex'($urandom), t_tex'($urandom)));
                sent++;
            end
        end
    endtask

    initial begin
        placer = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_COEF_A;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        offer <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity placement from reset
        push_vertex(make_vertex(1, 0, 0, 0, 0, 16'h0000, 16'h0000));
        push_vertex(make_vertex(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                16'hFFFF, 16'hFFFF));
        push_vertex(make_vertex(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                16'h0000, 16'hFFFF));
        push_vertex(make_vertex(0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                16'hFFFF, 16'h0000));
        push_vertex(make_vertex(0, COORD_MIN, COORD_MAX, 0, 0, 16'h8001, 16'h7FFE));
        push_vertex(make_vertex(1, 100, -200, 5, 5, 16'h1234, 16'hABCD));
        push_vertex(make_vertex(0, -7, 9, 0, 0, 16'h5555, 16'hAAAA));

        // extreme coefficients and translations
        settle();
        program_transform(COEF_LOW, COEF_HIGH, 16'sd1, -16'sd1, COORD_MAX, COORD_MIN);
        push_vertex(make_vertex(1, 0, 0, 0, 0, 16'h0001, 16'h8000));
        push_vertex(make_vertex(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                16'hFFFF, 16'hFFFF));
        push_vertex(make_vertex(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                16'h0000, 16'h0000));
        push_vertex(make_vertex(0, 1, -1, 0, 0, 16'h00FF, 16'hFF00));
        push_vertex(make_vertex(0, -1, 1, 0, 0, 16'hF0F0, 16'h0F0F));
        push_vertex(make_vertex(0, -3, 7, 0, -9, 16'h3C3C, 16'hC3C3));

        // floor rounding of small and negative products
        settle();
        program_transform(16'sd1, -16'sd1, 16'sd4095, -16'sd4097, COORD_ZERO, -24'sd1);
        push_vertex(make_vertex(1, -1, 0, 0, 0, 16'h0000, 16'h0000));
        push_vertex(make_vertex(0, 1, 0, 0, 0, 16'h0000, 16'h0000));
        push_vertex(make_vertex(0, 0, 1, 0, 0, 16'h0000, 16'h0000));
        push_vertex(make_vertex(0, 4096, -4096, -1, 1, 16'h0000, 16'h0000));
        push_vertex(make_vertex(0, -5000, 3000, 0, 0, 16'h0000, 16'h0000));
        push_vertex(make_vertex(0, COORD_MAX, COORD_MIN, 0, 0, 16'hFFFF, 16'hFFFF));
        push_vertex(make_vertex(1, 200, 300, 0, 0, 16'h7777, 16'h8888));

        for (int p = 0; p < 8; p++) begin
            settle();
            phase_no = p;
            case (p)
                0: program_transform(COEF_LOW, COEF_LOW, COEF_LOW, COEF_LOW,
                                     COORD_MIN, COORD_MIN);
                1: program_transform(COEF_HIGH, COEF_HIGH, COEF_HIGH, COEF_HIGH,
                                     COORD_MAX, COORD_MAX);
                default: program_transform(rand_coef(), rand_coef(), rand_coef(),
                                           rand_coef(), rand_coord(), rand_coord());
            endcase
            run_lists(200);
        end

        settle();
        calm = 1'b1;
        program_transform(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                          rand_coord(), rand_coord());
        run_lists(100);

        settle();
        repeat (8) @(posedge i_clk);
        if (placer.bad_results == 0 && placer.outstanding() == 0)
            $display("affine_vertex_place_with_bounds: match");
        else
            $display("affine_vertex_place_with_bounds: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/avf_pkg.sv
src/avf_cfg.sv
src/avf_xform.sv
src/avf_bounds.sv
src/affine_vertex_place_with_bounds.sv
bench/testbench.sv
